[hdl/periodic_min_image_distance_top_defines.svh]
// assertion macros for the periodic minimum-image distance block
`ifndef PERIODIC_MIN_IMAGE_DISTANCE_TOP_DEFINES_SVH
`define PERIODIC_MIN_IMAGE_DISTANCE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define PMID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pmid assertion failed");
// checked on every clock edge, reset included
`define PMID_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("pmid assertion failed");
`else
`define PMID_ASSERT(lbl, prop)
`define PMID_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[hdl/pmid_pkg.sv]
// shared types and constants of the periodic minimum-image distance block
package pmid_pkg;

  localparam int unsigned NR_W = 35;
  localparam int unsigned V_W  = 40;
  localparam logic signed [V_W-1:0] SAT_POS = V_W'(64'sd2147483646);
  localparam logic signed [V_W-1:0] SAT_NEG = V_W'(-64'sd2147483646);
  localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    REG_LAT_A = 3'd0,
    REG_LAT_B = 3'd1,
    REG_LAT_C = 3'd2,
    REG_INV_A = 3'd3,
    REG_INV_B = 3'd4,
    REG_INV_C = 3'd5
  } pmid_reg_e;

  typedef struct packed {
    logic signed [31:0] e00;
    logic signed [31:0] e10;
    logic signed [31:0] e11;
    logic signed [31:0] e20;
    logic signed [31:0] e21;
    logic signed [31:0] e22;
  } pmid_tri_t;

  // negated wrapped cell offset, floored to Q.16
  typedef struct packed {
    logic signed [NR_W-1:0] nr0;
    logic signed [NR_W-1:0] nr1;
    logic signed [NR_W-1:0] nr2;
  } pmid_img_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pmid_qstat_t;

endpackage

[hdl/pmid_front.sv]
// front pipeline: difference, fractional wrap and back-conversion of one query
module pmid_front
  import pmid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmid_tri_t          lat_i,
  input  pmid_tri_t          inv_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] p_x_i,
  input  logic signed [31:0] p_y_i,
  input  logic signed [31:0] p_z_i,
  input  logic signed [31:0] q_x_i,
  input  logic signed [31:0] q_y_i,
  input  logic signed [31:0] q_z_i,
  input  pmid_qstat_t        qstat_i,
  output logic               push_o,
  output pmid_img_t          push_data_o
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [31:0] d0_q, d1_q, d2_q;
  logic [31:0] p00_q, p10_q, p20_q, p11_q, p21_q, p22_q;
  logic [15:0] f0_q, f1_q, f2_q;
  logic signed [48:0] m00_q, m10_q, m20_q, m11_q, m21_q, m22_q;
  pmid_img_t img_q;
  logic [31:0] s0, s1;
  logic signed [50:0] r0, r1, r2, n0, n1, n2;

  assign en         = !(v5_q && qstat_i.full);
  assign in_stall_o = !en;
  assign push_o      = v5_q && !qstat_i.full;
  assign push_data_o = img_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // only the low 32 bits reach the fraction, so everything wraps mod 2^32
  assign s0 = p00_q + p10_q + p20_q;
  assign s1 = p11_q + p21_q;

  assign r0 = 51'(m00_q) + 51'(m10_q) + 51'(m20_q);
  assign r1 = 51'(m11_q) + 51'(m21_q);
  assign r2 = 51'(m22_q);
  assign n0 = -r0;
  assign n1 = -r1;
  assign n2 = -r2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q  <= p_x_i - q_x_i;
      d1_q  <= p_y_i - q_y_i;
      d2_q  <= p_z_i - q_z_i;
      p00_q <= inv_i.e00 * d0_q;
      p10_q <= inv_i.e10 * d1_q;
      p20_q <= inv_i.e20 * d2_q;
      p11_q <= inv_i.e11 * d1_q;
      p21_q <= inv_i.e21 * d2_q;
      p22_q <= inv_i.e22 * d2_q;
      f0_q  <= s0[31:16];
      f1_q  <= s1[31:16];
      f2_q  <= p22_q[31:16];
      m00_q <= 49'($signed({1'b0, f0_q})) * 49'(lat_i.e00);
      m10_q <= 49'($signed({1'b0, f1_q})) * 49'(lat_i.e10);
      m20_q <= 49'($signed({1'b0, f2_q})) * 49'(lat_i.e20);
      m11_q <= 49'($signed({1'b0, f1_q})) * 49'(lat_i.e11);
      m21_q <= 49'($signed({1'b0, f2_q})) * 49'(lat_i.e21);
      m22_q <= 49'($signed({1'b0, f2_q})) * 49'(lat_i.e22);
      img_q.nr0 <= n0[50:16];
      img_q.nr1 <= n1[50:16];
      img_q.nr2 <= n2[50:16];
    end
  end

endmodule

[hdl/pmid_queue.sv]
// short queue between the front and the image scan
module pmid_queue
  import pmid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pmid_img_t   push_data_i,
  input  logic        pop_i,
  output pmid_img_t   pop_data_o,
  output pmid_qstat_t stat_o
);
`include "periodic_min_image_distance_top_defines.svh"

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  pmid_img_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (AW+1)'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  `PMID_ASSERT(a_no_push_full, push_i |-> (!stat_o.full || pop_i))
  `PMID_ASSERT(a_no_pop_empty, pop_i |-> !stat_o.empty)
  `PMID_ASSERT(a_cnt_range, cnt_q <= (AW+1)'(DEPTH))

endmodule

[hdl/pmid_back.sv]
// back end: pipelined image scan, running minimum and bit-pair square root
module pmid_back
  import pmid_pkg::*;
#(
  parameter int IMAGE_REACH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pmid_tri_t   lat_i,
  input  pmid_qstat_t qstat_i,
  input  pmid_img_t   pop_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] min_distance_o
);
`include "periodic_min_image_distance_top_defines.svh"

  localparam int unsigned CW = $clog2(IMAGE_REACH + 1) + 1;
  localparam logic signed [CW-1:0] RMAX = CW'(IMAGE_REACH);
  localparam logic signed [CW-1:0] RMIN = CW'(-IMAGE_REACH);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_ROOT = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q;
  pmid_img_t cur_q;
  logic signed [CW-1:0] a_q, b_q, c_q;
  logic last_img;

  logic p1_v_q, p1_last_q, p2_v_q, p2_last_q;
  logic signed [V_W-1:0] v0_q, v1_q, v2_q;
  logic [61:0] sq0_q, sq1_q, sq2_q;
  logic sat_q;
  logic [63:0] best_q, best_d, s_img;

  logic [63:0] rad_q;
  logic [35:0] rem_q, rem_n, trial;
  logic [31:0] root_q;
  logic [4:0]  step_q;
  logic        load;
  logic        out_valid_q;
  logic [30:0] out_q;

  logic signed [V_W-1:0] v0_d, v1_d, v2_d;
  logic sat0, sat1, sat2;
  logic [30:0] m0, m1, m2;

  assign last_img = (a_q == RMAX) && (b_q == RMAX) && (c_q == RMAX);
  assign pop_o    = (state_q == ST_IDLE) && !qstat_i.empty;
  assign load     = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // image vector n.T - r, floored to Q.16
  assign v0_d = V_W'(a_q) * V_W'(lat_i.e00) + V_W'(b_q) * V_W'(lat_i.e10)
              + V_W'(c_q) * V_W'(lat_i.e20) + V_W'(cur_q.nr0);
  assign v1_d = V_W'(b_q) * V_W'(lat_i.e11) + V_W'(c_q) * V_W'(lat_i.e21)
              + V_W'(cur_q.nr1);
  assign v2_d = V_W'(c_q) * V_W'(lat_i.e22) + V_W'(cur_q.nr2);

  assign sat0 = (v0_q > SAT_POS) || (v0_q < SAT_NEG);
  assign sat1 = (v1_q > SAT_POS) || (v1_q < SAT_NEG);
  assign sat2 = (v2_q > SAT_POS) || (v2_q < SAT_NEG);
  assign m0 = v0_q[V_W-1] ? 31'(-v0_q) : v0_q[30:0];
  assign m1 = v1_q[V_W-1] ? 31'(-v1_q) : v1_q[30:0];
  assign m2 = v2_q[V_W-1] ? 31'(-v2_q) : v2_q[30:0];

  assign s_img  = sat_q ? '1 : (64'(sq0_q) + 64'(sq1_q) + 64'(sq2_q));
  assign best_d = (s_img < best_q) ? s_img : best_q;

  assign rem_n = {rem_q[33:0], rad_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= pop_data_i;
    v0_q  <= v0_d;
    v1_q  <= v1_d;
    v2_q  <= v2_d;
    sat_q <= sat0 || sat1 || sat2;
    sq0_q <= 62'(m0) * 62'(m0);
    sq1_q <= 62'(m1) * 62'(m1);
    sq2_q <= 62'(m2) * 62'(m2);
    if (load) out_q <= (root_q[31] ? OUT_MAX : root_q[30:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      p1_v_q      <= 1'b0;
      p1_last_q   <= 1'b0;
      p2_v_q      <= 1'b0;
      p2_last_q   <= 1'b0;
      best_q      <= '1;
      rad_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      p1_v_q    <= (state_q == ST_SCAN);
      p1_last_q <= (state_q == ST_SCAN) && last_img;
      p2_v_q    <= p1_v_q;
      p2_last_q <= p1_last_q;
      if (p2_v_q) best_q <= best_d;

      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            a_q     <= RMIN;
            b_q     <= RMIN;
            c_q     <= RMIN;
            best_q  <= '1;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (c_q == RMAX) begin
            c_q <= RMIN;
            if (b_q == RMAX) begin
              b_q <= RMIN;
              a_q <= a_q + 1'b1;
            end else begin
              b_q <= b_q + 1'b1;
            end
          end else begin
            c_q <= c_q + 1'b1;
          end
          if (last_img) state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (p2_v_q && p2_last_q) begin
            rad_q   <= best_d;
            rem_q   <= '0;
            root_q  <= '0;
            step_q  <= '0;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (rem_n >= trial) begin
            rem_q  <= rem_n - trial;
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q  <= rem_n;
            root_q <= {root_q[30:0], 1'b0};
          end
          rad_q  <= {rad_q[61:0], 2'b00};
          step_q <= step_q + 1'b1;
          if (step_q == 5'd31) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign min_distance_o = out_q;

  `PMID_ASSERT(a_load_free_slot, load |-> (!out_valid_q || !out_stall_i))
  `PMID_ASSERT(a_scan_feeds_pipe, (state_q == ST_SCAN) |=> p1_v_q)
  `PMID_ASSERT(a_root_after_last, $rose(state_q == ST_ROOT) |-> $past(p2_last_q))

endmodule

[hdl/periodic_min_image_distance_top.sv]
// top level of the periodic minimum-image distance block
// the back end scans one lattice image per cycle, followed by a 32-step square root,
//   and pops the next query only after the previous result is loaded for output
// the front keeps accepting queries into a 4-entry queue while the back end scans
// reset (rst_ni low, asynchronous) empties all pipes and loads identity lattices
module periodic_min_image_distance_top
  import pmid_pkg::*;
#(
  parameter int IMAGE_REACH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  // query channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] p_x_i,
  input  logic signed [31:0] p_y_i,
  input  logic signed [31:0] p_z_i,
  input  logic signed [31:0] q_x_i,
  input  logic signed [31:0] q_y_i,
  input  logic signed [31:0] q_z_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [30:0]        min_distance_o
);

  // lattice and inverse registers, two signed Q15.16 entries each, low half first
  logic [63:0] lat_a_q, lat_b_q, lat_c_q, inv_a_q, inv_b_q, inv_c_q;
  pmid_tri_t   lat, inv;

  logic        push, pop;
  pmid_img_t   push_data, pop_data;
  pmid_qstat_t qstat;

  // writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_a_q <= 64'h0000_0000_0001_0000;
      lat_b_q <= 64'h0000_0000_0001_0000;
      lat_c_q <= 64'h0001_0000_0000_0000;
      inv_a_q <= 64'h0000_0000_0001_0000;
      inv_b_q <= 64'h0000_0000_0001_0000;
      inv_c_q <= 64'h0001_0000_0000_0000;
    end else if (cfg_valid_i) begin
      unique case (pmid_reg_e'(cfg_index_i))
        REG_LAT_A: lat_a_q <= cfg_data_i;
        REG_LAT_B: lat_b_q <= cfg_data_i;
        REG_LAT_C: lat_c_q <= cfg_data_i;
        REG_INV_A: inv_a_q <= cfg_data_i;
        REG_INV_B: inv_b_q <= cfg_data_i;
        REG_INV_C: inv_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unpack the lower-triangular matrices
  assign lat.e00 = lat_a_q[31:0];
  assign lat.e10 = lat_a_q[63:32];
  assign lat.e11 = lat_b_q[31:0];
  assign lat.e20 = lat_b_q[63:32];
  assign lat.e21 = lat_c_q[31:0];
  assign lat.e22 = lat_c_q[63:32];
  assign inv.e00 = inv_a_q[31:0];
  assign inv.e10 = inv_a_q[63:32];
  assign inv.e11 = inv_b_q[31:0];
  assign inv.e20 = inv_b_q[63:32];
  assign inv.e21 = inv_c_q[31:0];
  assign inv.e22 = inv_c_q[63:32];

  // front: wraps the difference into the unit cell and hands the offset on
  pmid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lat_i       (lat),
    .inv_i       (inv),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .p_x_i       (p_x_i),
    .p_y_i       (p_y_i),
    .p_z_i       (p_z_i),
    .q_x_i       (q_x_i),
    .q_y_i       (q_y_i),
    .q_z_i       (q_z_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue
  pmid_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (qstat)
  );

  // back: image scan, minimum, root and output register
  pmid_back #(
    .IMAGE_REACH (IMAGE_REACH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lat_i          (lat),
    .qstat_i        (qstat),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .min_distance_o (min_distance_o)
  );

endmodule
